/* rtl/quad_x_motor_mixer_with_slew_macros.svh */
// Assertion macros for the quad X motor mixer checker.
`ifndef QUAD_X_MOTOR_MIXER_WITH_SLEW_MACROS_SVH
`define QUAD_X_MOTOR_MIXER_WITH_SLEW_MACROS_SVH
// implication checked every clock outside reset
`define QXM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qxm check failed");
// next-cycle implication
`define QXM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qxm check failed");
`endif

/* rtl/qxm_pkg.sv */
// Shared types, constants and codes for the quad X motor mixer.
package qxm_pkg;
  localparam int unsigned IDLE_LIMIT_DEF = 200;
  localparam logic [9:0] PM_FULL = 10'd1000;
  localparam logic [9:0] IDLE_RST = 10'd50;
  localparam logic [9:0] SLEW_RST = 10'd10;

  typedef enum logic [1:0] {
    OP_MIX   = 2'd0,
    OP_RESET = 2'd1,
    OP_PRIME = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_IDLE   = 2'd0,
    CFG_MAX    = 2'd1,
    CFG_SPREAD = 2'd2,
    CFG_SLEW   = 2'd3
  } cfg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item, do throttle/ramp/mix
    logic span;      // compute span, headroom, start decision
    logic div_start; // start scale division
    logic div_step;  // one quotient bit
    logic apply;     // apply scale to motors
    logic shift;     // shift and clamp
    logic report;    // compute feedback into output regs
  } qxm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_scale;
    logic div_done;
  } qxm_sts_t;
endpackage

/* rtl/quad_x_motor_mixer_with_slew.sv */
// Top level of the quad X motor mixer with throttle slew limiting.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready   | operation, throttle, trim, r/p/y
//  out_    | output    | out_valid/out_ready | four motors, throttle, feedback
//  cfg_    | input     | cfg_we              | cfg_index, cfg_data
//
// Mix: load, span, decide, shift, report; scaling: 12 1-bit divide steps, apply.
// Reset, prime and unused items are handled at load and return no result.
// Synchronous active-low reset restores register defaults and clears the ramp.
// The result sits in an output register; a new item is taken while it waits,
// and only the report step stalls until that held result is taken.
module quad_x_motor_mixer_with_slew
  import qxm_pkg::*;
#(
  parameter int unsigned IDLE_LIMIT = IDLE_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [9:0]         in_pilot_throttle,
  input  logic signed [10:0] in_altitude_trim,
  input  logic signed [15:0] in_roll_cmd,
  input  logic signed [15:0] in_pitch_cmd,
  input  logic signed [15:0] in_yaw_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [13:0]        out_motor_rear_right,
  output logic [13:0]        out_motor_front_right,
  output logic [13:0]        out_motor_rear_left,
  output logic [13:0]        out_motor_front_left,
  output logic [9:0]         out_ramped_throttle,
  output logic [9:0]         out_lowest_motor,
  output logic [9:0]         out_highest_motor,
  output logic [9:0]         out_motor_spread,
  output logic [9:0]         out_attitude_scale,
  output logic               out_hit_ceiling,
  output logic               out_hit_floor,
  output logic               out_was_scaled
);
  qxm_cmd_t cmd;
  qxm_sts_t sts;

  // sequencer: one item at a time
  qxm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation,
    .out_valid, .out_ready, .sts, .cmd
  );

  // arithmetic and state
  qxm_dpath #(.IDLE_LIMIT(IDLE_LIMIT)) u_dpath (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .cmd, .sts,
    .in_operation, .in_pilot_throttle, .in_altitude_trim,
    .in_roll_cmd, .in_pitch_cmd, .in_yaw_cmd,
    .out_motor_rear_right, .out_motor_front_right,
    .out_motor_rear_left, .out_motor_front_left,
    .out_ramped_throttle, .out_lowest_motor, .out_highest_motor,
    .out_motor_spread, .out_attitude_scale,
    .out_hit_ceiling, .out_hit_floor, .out_was_scaled
  );
endmodule

/* rtl/qxm_ctrl.sv */
// Sequencer for the quad X motor mixer.
module qxm_ctrl
  import qxm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [1:0] in_operation,
  output logic     out_valid,
  input  logic     out_ready,
  input  qxm_sts_t sts,
  output qxm_cmd_t cmd
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SPAN  = 7'b0000010,
    S_DIVS  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_APPLY = 7'b0010000,
    S_SHIFT = 7'b0100000,
    S_REP   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;
  logic   acc, mix;

  // new items are taken only in idle; a held result stalls only the report step
  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign mix       = (op_t'(in_operation) == OP_MIX);
  assign out_valid = ov_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    ov_nxt = ov_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = acc;
        if (acc && mix) state_nxt = S_SPAN;
      end
      S_SPAN: begin
        cmd.span = 1'b1;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        if (sts.need_scale) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = S_REP;
      end
      S_REP: begin
        if (!ov_r || out_ready) begin
          cmd.report = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule

/* rtl/qxm_dpath.sv */
// Datapath: config regs, ramp, mixer, scale divider, shift and feedback.
module qxm_dpath
  import qxm_pkg::*;
#(
  parameter int unsigned IDLE_LIMIT = IDLE_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data,
  input  qxm_cmd_t           cmd,
  output qxm_sts_t           sts,
  input  logic [1:0]         in_operation,
  input  logic [9:0]         in_pilot_throttle,
  input  logic signed [10:0] in_altitude_trim,
  input  logic signed [15:0] in_roll_cmd,
  input  logic signed [15:0] in_pitch_cmd,
  input  logic signed [15:0] in_yaw_cmd,
  output logic [13:0]        out_motor_rear_right,
  output logic [13:0]        out_motor_front_right,
  output logic [13:0]        out_motor_rear_left,
  output logic [13:0]        out_motor_front_left,
  output logic [9:0]         out_ramped_throttle,
  output logic [9:0]         out_lowest_motor,
  output logic [9:0]         out_highest_motor,
  output logic [9:0]         out_motor_spread,
  output logic [9:0]         out_attitude_scale,
  output logic               out_hit_ceiling,
  output logic               out_hit_floor,
  output logic               out_was_scaled
);
  localparam logic [9:0] IDLE_CAP = 10'(IDLE_LIMIT);
  localparam int QW = 12; // quotient bits: scale_q12 < 4096 when scaling

  logic [9:0] idle_r, max_r, spread_r, slew_r;
  logic [9:0] ramp_r;
  logic       rvalid_r;

  // motors: max magnitude 16000 + 98304 -> 19 bits signed
  logic signed [18:0] m_r [4];
  logic signed [18:0] t16_r;
  logic signed [18:0] lo_r, hi_r;
  logic [14:0]        avail_r;
  logic [18:0]        span_r;
  logic               scaled_r, need_r;
  logic [12:0]        q_r;
  logic [31:0]        rem_r;
  logic [3:0]         cnt_r;
  logic               hit_hi_r, hit_lo_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r <= IDLE_RST; max_r <= PM_FULL; spread_r <= PM_FULL; slew_r <= SLEW_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IDLE: begin
          idle_r <= (cfg_data > IDLE_CAP) ? IDLE_CAP : cfg_data;
          if (max_r < ((cfg_data > IDLE_CAP) ? IDLE_CAP : cfg_data))
            max_r <= (cfg_data > IDLE_CAP) ? IDLE_CAP : cfg_data;
        end
        CFG_MAX:
          max_r <= (cfg_data > PM_FULL) ? ((PM_FULL < idle_r) ? idle_r : PM_FULL)
                 : ((cfg_data < idle_r) ? idle_r : cfg_data);
        CFG_SPREAD: spread_r <= (cfg_data > PM_FULL) ? PM_FULL : cfg_data;
        CFG_SLEW:   slew_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // throttle clamp and slew
  logic signed [11:0] sum;
  logic [9:0]  thr, thr0, prime_v, ramp_nxt, dstep;
  logic        rvalid_nxt;
  always_comb begin
    sum  = $signed({2'b00, in_pilot_throttle}) + 12'(in_altitude_trim);
    thr0 = (sum < 0) ? 10'd0 : (sum > $signed({2'b00, PM_FULL})) ? PM_FULL : sum[9:0];
    thr  = (thr0 < idle_r) ? idle_r : (thr0 > max_r) ? max_r : thr0;
    prime_v = (in_pilot_throttle < idle_r) ? idle_r
            : (in_pilot_throttle > max_r) ? max_r : in_pilot_throttle;
    dstep = thr - ramp_r;
    if (dstep > slew_r) dstep = slew_r;
    ramp_nxt = ramp_r;
    rvalid_nxt = rvalid_r;
    unique case (op_t'(in_operation))
      OP_RESET: begin ramp_nxt = '0; rvalid_nxt = 1'b0; end
      OP_PRIME: begin ramp_nxt = prime_v; rvalid_nxt = 1'b1; end
      OP_MIX: begin
        rvalid_nxt = 1'b1;
        if (!rvalid_r || thr <= ramp_r) ramp_nxt = thr;
        else ramp_nxt = ramp_r + dstep;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_r <= '0; rvalid_r <= 1'b0;
    end else if (cmd.load) begin
      ramp_r <= ramp_nxt; rvalid_r <= rvalid_nxt;
    end
  end

  // mixing, using the updated ramp value
  logic signed [18:0] t16n, r, p, y;
  assign t16n = 19'({ramp_nxt, 4'b0000});
  assign r = 19'(in_roll_cmd);
  assign p = 19'(in_pitch_cmd);
  assign y = 19'(in_yaw_cmd);

  // span helpers
  logic signed [18:0] mn, mx, mn01, mn23, mx01, mx23;
  always_comb begin
    mn01 = (m_r[0] < m_r[1]) ? m_r[0] : m_r[1];
    mn23 = (m_r[2] < m_r[3]) ? m_r[2] : m_r[3];
    mx01 = (m_r[0] > m_r[1]) ? m_r[0] : m_r[1];
    mx23 = (m_r[2] > m_r[3]) ? m_r[2] : m_r[3];
    mn = (mn01 < mn23) ? mn01 : mn23;
    mx = (mx01 > mx23) ? mx01 : mx23;
  end

  logic [14:0] av_lvl, av_spr, av;
  logic [18:0] spn;
  assign av_lvl = 15'({max_r - idle_r, 4'b0000});
  assign av_spr = 15'({spread_r, 4'b0000});
  assign av     = (av_spr < av_lvl) ? av_spr : av_lvl;
  assign spn    = 19'(mx - mn);

  // restoring divider: (avail << 12) / span, one bit per step
  logic [31:0] rem_sh, trial;
  assign rem_sh = {rem_r[30:0], 1'b0};
  assign trial  = rem_sh - 32'(span_r);

  // apply: round(|d| * q / 4096) half away
  logic signed [18:0] d_a [4];
  logic [17:0]        mag [4];
  logic [30:0]        prod [4];
  logic signed [18:0] qv [4];
  // shift
  logic signed [19:0] idle16, max16, off, lo_s, hi_s;
  logic               satl, sath;
  logic signed [19:0] mo [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      d_a[i]  = m_r[i] - t16_r;
      mag[i]  = d_a[i][18] ? 18'(-d_a[i]) : 18'(d_a[i]);
      prod[i] = 31'(mag[i]) * 31'(q_r) + 31'd2048;
      qv[i]   = 19'(prod[i][30:12]);
    end
    idle16 = 20'({idle_r, 4'b0000});
    max16  = 20'({max_r, 4'b0000});
    lo_s = 20'(mn); hi_s = 20'(mx);
    off = '0; satl = 1'b0; sath = 1'b0;
    if (lo_s < idle16) begin satl = 1'b1; off = idle16 - lo_s; end
    if (hi_s + off > max16) begin sath = 1'b1; off = max16 - hi_s; end
    for (int i = 0; i < 4; i++) begin
      mo[i] = 20'(m_r[i]) + off;
      if (mo[i] < idle16) mo[i] = idle16;
      if (mo[i] > max16) mo[i] = max16;
    end
  end

  // feedback
  logic [9:0]  lo_pm, hi_pm;
  logic [22:0] spm;
  assign lo_pm = 10'(mn >>> 4);
  assign hi_pm = 10'(mx >>> 4);
  assign spm   = 23'(q_r) * 23'(PM_FULL);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t16_r   <= t16n;
      m_r[0]  <= t16n - r + p - y;
      m_r[1]  <= t16n - r - p + y;
      m_r[2]  <= t16n + r + p + y;
      m_r[3]  <= t16n + r - p - y;
      q_r     <= 13'd4096;
      scaled_r <= 1'b0;
    end
    if (cmd.span) begin
      avail_r <= av;
      span_r  <= spn;
      need_r  <= (spn > 19'(av)) && (spn > 19'd1);
    end
    if (cmd.div_start) begin
      rem_r    <= 32'(avail_r);
      q_r      <= '0;
      cnt_r    <= 4'(QW);
      scaled_r <= 1'b1;
    end
    if (cmd.div_step) begin
      // dividend avail*4096: shift in zeros after the avail bits
      if (rem_sh >= 32'(span_r)) begin
        rem_r <= trial; q_r <= {q_r[11:0], 1'b1};
      end else begin
        rem_r <= rem_sh; q_r <= {q_r[11:0], 1'b0};
      end
      cnt_r <= cnt_r - 4'd1;
    end
    if (cmd.apply) begin
      for (int i = 0; i < 4; i++)
        m_r[i] <= d_a[i][18] ? t16_r - qv[i] : t16_r + qv[i];
    end
    if (cmd.shift) begin
      for (int i = 0; i < 4; i++) m_r[i] <= 19'(mo[i]);
      hit_hi_r <= sath;
      hit_lo_r <= satl;
    end
    if (cmd.report) begin
      out_motor_rear_right  <= 14'(m_r[0]);
      out_motor_front_right <= 14'(m_r[1]);
      out_motor_rear_left   <= 14'(m_r[2]);
      out_motor_front_left  <= 14'(m_r[3]);
      out_ramped_throttle   <= ramp_r;
      out_lowest_motor      <= lo_pm;
      out_highest_motor     <= hi_pm;
      out_motor_spread      <= hi_pm - lo_pm;
      out_attitude_scale    <= spm[21:12];
      out_hit_ceiling       <= hit_hi_r || (hi_pm >= max_r);
      out_hit_floor         <= hit_lo_r || (lo_pm <= idle_r);
      out_was_scaled        <= scaled_r;
    end
  end

  // rem starts at avail < span, so the integer bit is zero; each of the 12
  // steps brings in one fraction bit => floor(avail*4096/span).
  assign sts.need_scale = need_r;
  assign sts.div_done   = (cnt_r == 4'd1);
endmodule

/* rtl/qxm_checker.sv */
// Port-level checker for the quad X motor mixer, bound to the top level.
`include "quad_x_motor_mixer_with_slew_macros.svh"
module qxm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] out_lowest_motor,
  input logic [9:0] out_highest_motor,
  input logic [9:0] out_motor_spread,
  input logic       out_was_scaled,
  input logic [9:0] out_attitude_scale
);
  `QXM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `QXM_ASSERT_IMP(a_order, out_valid, out_lowest_motor <= out_highest_motor)
  `QXM_ASSERT_IMP(a_spread, out_valid,
    out_motor_spread == out_highest_motor - out_lowest_motor)
  `QXM_ASSERT_IMP(a_unscaled, out_valid && !out_was_scaled,
    out_attitude_scale == 10'd1000)
endmodule

bind quad_x_motor_mixer_with_slew qxm_checker u_qxm_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_lowest_motor, .out_highest_motor, .out_motor_spread,
  .out_was_scaled, .out_attitude_scale
);
